### rtl/qrs_pkg.sv
// shared types and constants for the query retry scheduler
// no dependencies; imported by qrs_unit, qrs_table and the top level
`default_nettype none

package qrs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_BITS   = 32;
    localparam int ADDR_BITS   = 16;
    localparam int ATT_BITS    = 4;
    localparam int DLY_BITS    = 16;
    localparam int PASS_BITS   = 2;
    localparam int CMD_BITS    = 2;
    localparam int PKT_BITS    = 3;
    localparam int RES_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int IN_BYTES_BITS  = 24;
    localparam int OUT_BYTES_BITS = 24;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RSP  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd2;

    // event codes
    localparam logic [RES_BITS-1:0] EV_TRIGGER  = 2'd0;
    localparam logic [RES_BITS-1:0] EV_EXPIRE   = 2'd1;
    localparam logic [RES_BITS-1:0] EV_OVERFLOW = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_DELAY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY_DELAY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ATTEMPTS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PER_PASS = 2'd3;

    // configuration reset values
    localparam logic [DLY_BITS-1:0]  RST_QUERY_DELAY  = 16'd2000;
    localparam logic [DLY_BITS-1:0]  RST_RETRY_DELAY  = 16'd3000;
    localparam logic [ATT_BITS-1:0]  RST_MAX_ATTEMPTS = 4'd3;
    localparam logic [PASS_BITS-1:0] RST_MAX_PER_PASS = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ATT_BITS-1:0]  att;
        logic [TIME_BITS-1:0] due;
    } t_entry;

endpackage

`default_nettype wire

### rtl/qrs_unit.sv
// shared add/subtract unit for time arithmetic
// depends on qrs_pkg
`default_nettype none

module qrs_unit (
    input  wire logic [qrs_pkg::TIME_BITS-1:0] i_a,
    input  wire logic [qrs_pkg::TIME_BITS-1:0] i_b,
    input  wire logic                          i_sub,
    output logic      [qrs_pkg::TIME_BITS-1:0] o_y
);
    import qrs_pkg::*;

    // wraps at TIME_BITS, subtract by two's complement
    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

`default_nettype wire

### rtl/qrs_table.sv
// entry store for pending queries: one write port, one read port
// depends on qrs_pkg
`default_nettype none

module qrs_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [qrs_pkg::IDX_BITS-1:0] i_widx,
    input  wire qrs_pkg::t_entry              i_wdata,
    input  wire logic [qrs_pkg::IDX_BITS-1:0] i_ridx,
    output qrs_pkg::t_entry                   o_rdata
);
    import qrs_pkg::*;

    t_entry r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_widx] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_ridx];

endmodule

`default_nettype wire

### rtl/query_retry_scheduler_top.sv
// query retry scheduler top level: sequencer, config registers, output stage
// depends on qrs_pkg, qrs_unit, qrs_table
// sequence: enqueue forms the due time, then appends one entry per packet; response scans for the address
//   and closes its gap; tick advances time, then runs max_per_pass scan passes, each expiry closing its gap
// throughput: one input word at a time; the next word is accepted only once the sequencer is back in idle
// reset: table empty, time zero, config registers at defaults; no clearing pass
`default_nettype none

module query_retry_scheduler_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input word: cmd [1:0], target_address [17:2], packet_count [20:18], zero pad
    input  wire logic [qrs_pkg::IN_BYTES_BITS-1:0]   s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // result word: event_res [1:0], event_address [17:2], zero pad
    output logic [qrs_pkg::OUT_BYTES_BITS-1:0]       m_axis_tdata,
    output logic                                     m_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [qrs_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [qrs_pkg::DLY_BITS-1:0]        i_cfg_data
);
    import qrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_DUE,
        S_ENQ_WR,
        S_RSP_SCAN,
        S_SHIFT,
        S_TICK_TIME,
        S_PASS,
        S_SCAN,
        S_PICK,
        S_FIN
    } t_state;

    t_state r_state;
    t_state r_ret;

    // config registers
    logic [DLY_BITS-1:0]  r_qdelay;
    logic [DLY_BITS-1:0]  r_rdelay;
    logic [ATT_BITS-1:0]  r_maxatt;
    logic [PASS_BITS-1:0] r_maxpass;

    // item registers
    logic [ADDR_BITS-1:0] r_addr;
    logic [PKT_BITS-1:0]  r_cnt;

    // table bookkeeping and time
    logic [CNT_BITS-1:0]  r_used;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] r_tmp;

    // scan state
    logic [CNT_BITS-1:0]  r_idx;
    logic [IDX_BITS-1:0]  r_rm;
    logic [IDX_BITS-1:0]  r_pick;
    logic                 r_found;
    logic [TIME_BITS-1:0] r_best;
    logic [PASS_BITS-1:0] r_pass;

    // held result, released once the next one is known (sets tlast)
    logic                 r_pend_valid;
    logic [RES_BITS-1:0]  r_pend_res;
    logic [ADDR_BITS-1:0] r_pend_addr;

    // output register
    logic                 r_ovalid;
    logic [RES_BITS-1:0]  r_ores;
    logic [ADDR_BITS-1:0] r_oaddr;
    logic                 r_olast;

    // input fields
    logic [CMD_BITS-1:0]  in_cmd;
    logic [ADDR_BITS-1:0] in_addr;
    logic [PKT_BITS-1:0]  in_cnt;

    assign in_cmd  = s_axis_tdata[CMD_BITS-1:0];
    assign in_addr = s_axis_tdata[CMD_BITS+ADDR_BITS-1:CMD_BITS];
    assign in_cnt  = s_axis_tdata[CMD_BITS+ADDR_BITS+PKT_BITS-1:CMD_BITS+ADDR_BITS];

    // table ports
    logic                 tbl_we;
    logic [IDX_BITS-1:0]  tbl_widx;
    t_entry               tbl_wdata;
    logic [IDX_BITS-1:0]  tbl_ridx;
    t_entry               tbl_rd;

    // shared unit ports
    logic [TIME_BITS-1:0] u_a;
    logic [TIME_BITS-1:0] u_b;
    logic                 u_sub;
    logic [TIME_BITS-1:0] u_y;

    // derived control
    logic                 out_free;
    logic                 can_emit;
    logic                 load_out;
    logic [CNT_BITS-1:0]  rm_next;
    logic                 shift_more;
    logic                 scan_end;
    logic                 better;
    logic                 rsp_match;
    logic                 table_full;
    logic                 do_trigger;

    assign out_free   = !r_ovalid || m_axis_tready;
    // a new result needs the held slot free, or the held one moving to the output
    assign can_emit   = !r_pend_valid || out_free;
    assign rm_next    = CNT_BITS'(r_rm) + CNT_BITS'(1);
    assign shift_more = rm_next < r_used;
    assign scan_end   = r_idx == r_used;
    assign table_full = r_used == CNT_BITS'(TABLE_DEPTH);
    // output register reloads from the held slot this cycle
    assign load_out   = r_pend_valid && out_free &&
                        ((r_state == S_PICK) || (r_state == S_FIN) ||
                         ((r_state == S_ENQ_WR) && (r_cnt != '0) && table_full));
    assign rsp_match  = (tbl_rd.addr == r_addr) && (tbl_rd.att != '0);
    // due means a positive signed gap; larger gap is more overdue
    assign better     = (u_y != '0) && !u_y[TIME_BITS-1] && (u_y > r_best);
    assign do_trigger = tbl_rd.att < r_maxatt;

    // read address follows the active loop
    always_comb begin
        unique case (r_state)
            S_SHIFT: tbl_ridx = rm_next[IDX_BITS-1:0];
            S_PICK:  tbl_ridx = r_pick;
            default: tbl_ridx = r_idx[IDX_BITS-1:0];
        endcase
    end

    // operand select for the shared unit
    always_comb begin
        u_a   = r_time;
        u_b   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            S_ENQ_DUE:   u_b = TIME_BITS'(r_qdelay);
            S_TICK_TIME: u_b = TIME_BITS'(1);
            S_SCAN: begin
                u_b   = tbl_rd.due;
                u_sub = 1'b1;
            end
            S_PICK: begin
                u_a = tbl_rd.due;
                u_b = TIME_BITS'(r_rdelay);
            end
            default: u_b = '0;
        endcase
    end

    // table write: append, close gap, or update on trigger
    always_comb begin
        tbl_we    = 1'b0;
        tbl_widx  = r_rm;
        tbl_wdata = tbl_rd;
        unique case (r_state)
            S_ENQ_WR: begin
                tbl_widx       = r_used[IDX_BITS-1:0];
                tbl_wdata.addr = r_addr;
                tbl_wdata.att  = '0;
                tbl_wdata.due  = r_tmp;
                tbl_we         = (r_cnt != '0) && !table_full;
            end
            S_SHIFT: begin
                tbl_we = shift_more;
            end
            S_PICK: begin
                tbl_widx      = r_pick;
                tbl_wdata.att = tbl_rd.att + ATT_BITS'(1);
                tbl_wdata.due = u_y;
                tbl_we        = do_trigger && can_emit && r_found;
            end
            default: tbl_we = 1'b0;
        endcase
    end

    qrs_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_widx  (tbl_widx),
        .i_wdata (tbl_wdata),
        .i_ridx  (tbl_ridx),
        .o_rdata (tbl_rd)
    );

    qrs_unit u_unit (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_sub (u_sub),
        .o_y   (u_y)
    );

    // sequencer, config and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_qdelay     <= RST_QUERY_DELAY;
            r_rdelay     <= RST_RETRY_DELAY;
            r_maxatt     <= RST_MAX_ATTEMPTS;
            r_maxpass    <= RST_MAX_PER_PASS;
            r_used       <= '0;
            r_time       <= '0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUERY_DELAY:  r_qdelay  <= i_cfg_data;
                    CFG_RETRY_DELAY:  r_rdelay  <= i_cfg_data;
                    CFG_MAX_ATTEMPTS: r_maxatt  <= i_cfg_data[ATT_BITS-1:0];
                    CFG_MAX_PER_PASS: r_maxpass <= i_cfg_data[PASS_BITS-1:0];
                    default:          r_qdelay  <= r_qdelay;
                endcase
            end

            // output word taken and nothing loaded behind it
            if (r_ovalid && m_axis_tready && !load_out) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_addr <= in_addr;
                        r_cnt  <= in_cnt;
                        r_idx  <= '0;
                        unique case (in_cmd)
                            CMD_ENQ:  r_state <= S_ENQ_DUE;
                            CMD_RSP:  r_state <= S_RSP_SCAN;
                            CMD_TICK: r_state <= S_TICK_TIME;
                            default:  r_state <= S_FIN;
                        endcase
                    end
                end

                S_ENQ_DUE: begin
                    r_tmp   <= u_y;
                    r_state <= S_ENQ_WR;
                end

                S_ENQ_WR: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else if (table_full) begin
                        // surplus dropped, one overflow word
                        if (can_emit) begin
                            if (r_pend_valid) begin
                                r_ovalid <= 1'b1;
                                r_ores   <= r_pend_res;
                                r_oaddr  <= r_pend_addr;
                                r_olast  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_res   <= EV_OVERFLOW;
                            r_pend_addr  <= r_addr;
                            r_state      <= S_FIN;
                        end
                    end else begin
                        r_used <= r_used + CNT_BITS'(1);
                        r_cnt  <= r_cnt - PKT_BITS'(1);
                    end
                end

                S_RSP_SCAN: begin
                    if (scan_end) begin
                        r_state <= S_FIN;
                    end else if (rsp_match) begin
                        r_rm    <= r_idx[IDX_BITS-1:0];
                        r_ret   <= S_FIN;
                        r_state <= S_SHIFT;
                    end else begin
                        r_idx <= r_idx + CNT_BITS'(1);
                    end
                end

                // close the gap one slot per cycle, then drop the tail
                S_SHIFT: begin
                    if (shift_more) begin
                        r_rm <= rm_next[IDX_BITS-1:0];
                    end else begin
                        r_used  <= r_used - CNT_BITS'(1);
                        r_state <= r_ret;
                    end
                end

                S_TICK_TIME: begin
                    r_time  <= u_y;
                    r_pass  <= '0;
                    r_state <= S_PASS;
                end

                S_PASS: begin
                    if (r_pass == r_maxpass) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_state <= S_SCAN;
                    end
                end

                // strict greater keeps the oldest on ties
                S_SCAN: begin
                    if (scan_end) begin
                        if (r_found) begin
                            r_state <= S_PICK;
                        end else begin
                            r_pass  <= r_pass + PASS_BITS'(1);
                            r_state <= S_PASS;
                        end
                    end else begin
                        if (better) begin
                            r_best  <= u_y;
                            r_pick  <= r_idx[IDX_BITS-1:0];
                            r_found <= 1'b1;
                        end
                        r_idx <= r_idx + CNT_BITS'(1);
                    end
                end

                S_PICK: begin
                    if (can_emit) begin
                        if (r_pend_valid) begin
                            r_ovalid <= 1'b1;
                            r_ores   <= r_pend_res;
                            r_oaddr  <= r_pend_addr;
                            r_olast  <= 1'b0;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_addr  <= tbl_rd.addr;
                        r_pass       <= r_pass + PASS_BITS'(1);
                        r_found      <= 1'b0;
                        if (do_trigger) begin
                            r_pend_res <= EV_TRIGGER;
                            r_state    <= S_PASS;
                        end else begin
                            r_pend_res <= EV_EXPIRE;
                            r_rm       <= r_pick;
                            r_ret      <= S_PASS;
                            r_state    <= S_SHIFT;
                        end
                    end
                end

                // release the held word as the final one of this item
                S_FIN: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_ovalid     <= 1'b1;
                        r_ores       <= r_pend_res;
                        r_oaddr      <= r_pend_addr;
                        r_olast      <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {{(OUT_BYTES_BITS - RES_BITS - ADDR_BITS){1'b0}}, r_oaddr, r_ores};

    // table fill never passes its depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_BITS'(TABLE_DEPTH))
        else $error("table fill count above depth");

    // fill count moves by at most one per cycle
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_used == $past(r_used)) || (r_used == $past(r_used) + CNT_BITS'(1))
                 || (r_used + CNT_BITS'(1) == $past(r_used)))
        else $error("fill count jumped");

    // time only advances in the tick step
    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_TICK_TIME) |=> (r_time == $past(r_time)))
        else $error("time changed outside tick");

    // a held word is never overwritten while the output is stalled
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_ovalid && !m_axis_tready) |=> r_pend_valid
            && (r_pend_res == $past(r_pend_res)) && (r_pend_addr == $past(r_pend_addr)))
        else $error("held result lost");

    // one word at a time: not ready right after acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted twice in a row");

endmodule

`default_nettype wire
